// File: rtl/assert_macros.svh
// Assertion macros used by the checker file of the string model.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/dsfs_pkg.sv
// Shared types, constants and the excitation window table of the string model.
`timescale 1ns / 1ps

package dsfs_pkg;

    localparam int DISP_W     = 32;
    localparam int COEF_W     = 18;
    localparam int GRID_W     = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;
    localparam int WIN_IDX_W  = 5;

    localparam logic [DISP_W-1:0] DISP_MAX = 32'h7FFF_FFFF;
    localparam logic [DISP_W-1:0] DISP_MIN = 32'h8000_0000;

    // Register indexes on the configuration channel.
    localparam logic [CFG_IDX_W-1:0] REG_GRID_INTERVALS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_CENTER    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_NEIGHBOUR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_PREVIOUS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PICKUP_POINT   = 3'd4;

    // Last value of the drain counter while the write-back pipeline empties.
    localparam logic [2:0] DRAIN_LAST = 3'd4;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_TICK,
        ST_EXCITE,
        ST_DRAIN,
        ST_PICK,
        ST_PWAIT,
        ST_RESULT
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_CLEAR,
        OP_TICK,
        OP_EXCITE,
        OP_PICK
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t op;
        logic    start;
        logic    rotate;
    } ctrl_cmd_t;

    // Raised-cosine window 0.5*(1-cos(2*pi*k/9)) in Q8.24; entries past the table add zero.
    function automatic logic signed [DISP_W-1:0] win_value(input logic [WIN_IDX_W-1:0] k);
        logic signed [DISP_W-1:0] v;
        case (k)
            5'd1:    v = 32'sd1962561;
            5'd2:    v = 32'sd6931942;
            5'd3:    v = 32'sd12582912;
            5'd4:    v = 32'sd16271321;
            5'd5:    v = 32'sd16271321;
            5'd6:    v = 32'sd12582912;
            5'd7:    v = 32'sd6931942;
            5'd8:    v = 32'sd1962561;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/damped_string_fdtd_step.sv
// Top level of the damped string finite-difference model: ports, configuration and output register.
`timescale 1ns / 1ps

// Damped string, explicit finite-difference step. The block keeps three
// displacement planes of up to MAX_POINTS grid points in three RAMs. An input
// transfer with tuser low advances the string one time step: the interior points
// 1..N-1 are recomputed one per cycle from the current and previous planes with
// the three Q2.16 coefficients, each result rounded to Q8.24 and clipped, and the
// planes then rotate. With tuser high the raised-cosine window is added to the
// current and previous planes, starting at max(excite_pos-5, 1) and stopping
// before point N. Every input transfer gives exactly one output transfer carrying
// the current displacement at the pickup point and a flag saying that some value
// written by that item was clipped. A tick sweeps the read port of the current
// plane over points 0..N before its result is offered. The input is taken one
// item at a time; a finished result waits in the output register while the next
// item is accepted. After reset a clearing pass writes zeros through all three
// planes, during which no input transfer is taken; configuration writes are
// accepted at any time and should only be issued while the block is idle.
module damped_string_fdtd_step #(
    parameter int MAX_POINTS   = 257,
    parameter int EXCITE_WIDTH = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input stream.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [15:0]                         s_tdata,   // [8:0] excite_pos, rest zero
    input  logic                                s_tuser,   // [0] req_type
    // Output stream.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [31:0]                         m_tdata,   // [31:0] pickup_value
    output logic                                m_tuser,   // [0] saturated
    // Configuration write channel.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dsfs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dsfs_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int IW = (AW > dsfs_pkg::GRID_W) ? AW : dsfs_pkg::GRID_W;
    localparam int CW = IW + 1;
    localparam logic [IW-1:0] N_MIN = IW'(2);
    localparam logic [IW-1:0] N_MAX = IW'(MAX_POINTS - 1);

    // Configuration registers.
    logic [dsfs_pkg::GRID_W-1:0]          grid_reg;
    logic signed [dsfs_pkg::COEF_W-1:0]   coef_center_reg;
    logic signed [dsfs_pkg::COEF_W-1:0]   coef_neighbour_reg;
    logic signed [dsfs_pkg::COEF_W-1:0]   coef_previous_reg;
    logic [dsfs_pkg::GRID_W-1:0]          pickup_reg;

    logic [IW-1:0] grid_ext;
    logic [IW-1:0] n_eff;

    dsfs_pkg::ctrl_cmd_t            cmd;
    logic [CW-1:0]                  cmd_idx;
    logic [dsfs_pkg::WIN_IDX_W-1:0] cmd_win;
    logic                           out_load;
    logic                           out_free;

    logic signed [31:0] pickup_value;
    logic               saturated;

    logic        m_tvalid_reg;
    logic [31:0] m_tdata_reg;
    logic        m_tuser_reg;

    // The register file never stalls a write.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_reg           <= 9'd64;
            coef_center_reg    <= 18'sd0;
            coef_neighbour_reg <= 18'sd65536;
            coef_previous_reg  <= -18'sd65536;
            pickup_reg         <= 9'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                dsfs_pkg::REG_GRID_INTERVALS: grid_reg           <= cfg_data[8:0];
                dsfs_pkg::REG_COEF_CENTER:    coef_center_reg    <= $signed(cfg_data);
                dsfs_pkg::REG_COEF_NEIGHBOUR: coef_neighbour_reg <= $signed(cfg_data);
                dsfs_pkg::REG_COEF_PREVIOUS:  coef_previous_reg  <= $signed(cfg_data);
                dsfs_pkg::REG_PICKUP_POINT:   pickup_reg         <= cfg_data[8:0];
                default:                      grid_reg           <= grid_reg;
            endcase
        end
    end

    // The grid size in use is held between two intervals and one less than the memory depth.
    always_comb
    begin
        grid_ext = IW'(grid_reg);
        if (grid_ext < N_MIN)
        begin
            n_eff = N_MIN;
        end
        else if (grid_ext > N_MAX)
        begin
            n_eff = N_MAX;
        end
        else
        begin
            n_eff = grid_ext;
        end
    end

    // The output register can take a new result when empty or being emptied.
    assign out_free = !m_tvalid_reg || m_tready;

    dsfs_ctrl #(
        .MAX_POINTS   (MAX_POINTS),
        .EXCITE_WIDTH (EXCITE_WIDTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (s_tvalid),
        .item_ready  (s_tready),
        .item_excite (s_tuser),
        .item_pos    (s_tdata[8:0]),
        .n_eff       (n_eff),
        .pickup      (pickup_reg),
        .out_free    (out_free),
        .cmd         (cmd),
        .cmd_idx     (cmd_idx),
        .cmd_win     (cmd_win),
        .out_load    (out_load)
    );

    dsfs_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cmd_idx        (cmd_idx),
        .cmd_win        (cmd_win),
        .n_eff          (n_eff),
        .coef_center    (coef_center_reg),
        .coef_neighbour (coef_neighbour_reg),
        .coef_previous  (coef_previous_reg),
        .pickup_value   (pickup_value),
        .saturated      (saturated)
    );

    // Output register: holds a result until its transfer completes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_tdata_reg <= pickup_value;
            m_tuser_reg <= saturated;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// File: rtl/dsfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module dsfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 257,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/dsfs_ctrl.sv
// Sequencer for the string model: clearing pass, tick sweep, excitation and pickup read.
`timescale 1ns / 1ps

module dsfs_ctrl #(
    parameter int MAX_POINTS   = 257,
    parameter int EXCITE_WIDTH = 10,
    localparam int AW   = $clog2(MAX_POINTS),
    localparam int IW   = (AW > dsfs_pkg::GRID_W) ? AW : dsfs_pkg::GRID_W,
    localparam int CW   = IW + 1,
    localparam int HALF = EXCITE_WIDTH / 2
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  logic                                item_excite,
    input  logic [dsfs_pkg::GRID_W-1:0]         item_pos,
    input  logic [IW-1:0]                       n_eff,
    input  logic [dsfs_pkg::GRID_W-1:0]         pickup,
    input  logic                                out_free,
    output dsfs_pkg::ctrl_cmd_t                 cmd,
    output logic [CW-1:0]                       cmd_idx,
    output logic [dsfs_pkg::WIN_IDX_W-1:0]      cmd_win,
    output logic                                out_load
);

    localparam logic [CW-1:0] HALF_C = CW'(HALF);
    localparam logic [CW-1:0] CLEAR_LAST = CW'(MAX_POINTS - 1);
    localparam logic [dsfs_pkg::WIN_IDX_W-1:0] WIN_LAST =
        dsfs_pkg::WIN_IDX_W'(EXCITE_WIDTH - 1);

    dsfs_pkg::state_t                 state_reg, state_next;
    logic [CW-1:0]                    idx_reg, idx_next;
    logic [dsfs_pkg::WIN_IDX_W-1:0]   win_reg, win_next;
    logic [2:0]                       drain_reg, drain_next;
    logic                             tick_reg, tick_next;

    logic [CW-1:0] n_ext;
    logic [CW-1:0] pos_ext;
    logic [CW-1:0] exc_start;

    // First excited point: centre minus half the window, never below point one.
    always_comb
    begin
        n_ext   = CW'(n_eff);
        pos_ext = CW'(item_pos);
        if (pos_ext > HALF_C)
        begin
            exc_start = pos_ext - HALF_C;
        end
        else
        begin
            exc_start = '0;
        end
        if (exc_start == '0)
        begin
            exc_start = CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dsfs_pkg::ST_CLEAR;
            idx_reg   <= '0;
            win_reg   <= '0;
            drain_reg <= '0;
            tick_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            win_reg   <= win_next;
            drain_reg <= drain_next;
            tick_reg  <= tick_next;
        end
    end

    // Next state and counters.
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        win_next   = win_reg;
        drain_next = drain_reg;
        tick_next  = tick_reg;
        case (state_reg)
            dsfs_pkg::ST_CLEAR:
            begin
                if (idx_reg == CLEAR_LAST)
                begin
                    state_next = dsfs_pkg::ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            dsfs_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    drain_next = '0;
                    win_next   = '0;
                    if (item_excite)
                    begin
                        tick_next = 1'b0;
                        idx_next  = exc_start;
                        if (exc_start >= n_ext)
                        begin
                            state_next = dsfs_pkg::ST_DRAIN;
                        end
                        else
                        begin
                            state_next = dsfs_pkg::ST_EXCITE;
                        end
                    end
                    else
                    begin
                        tick_next  = 1'b1;
                        idx_next   = '0;
                        state_next = dsfs_pkg::ST_TICK;
                    end
                end
            end
            dsfs_pkg::ST_TICK:
            begin
                if (idx_reg == n_ext)
                begin
                    state_next = dsfs_pkg::ST_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            dsfs_pkg::ST_EXCITE:
            begin
                if ((win_reg == WIN_LAST) || (idx_reg + CW'(1) >= n_ext))
                begin
                    state_next = dsfs_pkg::ST_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                    win_next = win_reg + dsfs_pkg::WIN_IDX_W'(1);
                end
            end
            dsfs_pkg::ST_DRAIN:
            begin
                drain_next = drain_reg + 3'd1;
                if (drain_reg == dsfs_pkg::DRAIN_LAST)
                begin
                    state_next = dsfs_pkg::ST_PICK;
                end
            end
            dsfs_pkg::ST_PICK:
            begin
                state_next = dsfs_pkg::ST_PWAIT;
            end
            dsfs_pkg::ST_PWAIT:
            begin
                state_next = dsfs_pkg::ST_RESULT;
            end
            dsfs_pkg::ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next = dsfs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dsfs_pkg::ST_IDLE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        item_ready = 1'b0;
        out_load   = 1'b0;
        cmd.op     = dsfs_pkg::OP_NONE;
        cmd.start  = 1'b0;
        cmd.rotate = 1'b0;
        cmd_idx    = idx_reg;
        cmd_win    = win_reg;
        case (state_reg)
            dsfs_pkg::ST_CLEAR:
            begin
                cmd.op = dsfs_pkg::OP_CLEAR;
            end
            dsfs_pkg::ST_IDLE:
            begin
                item_ready = 1'b1;
                cmd.start  = item_valid;
            end
            dsfs_pkg::ST_TICK:
            begin
                cmd.op = dsfs_pkg::OP_TICK;
            end
            dsfs_pkg::ST_EXCITE:
            begin
                cmd.op = dsfs_pkg::OP_EXCITE;
            end
            dsfs_pkg::ST_DRAIN:
            begin
                cmd.rotate = tick_reg && (drain_reg == dsfs_pkg::DRAIN_LAST);
            end
            dsfs_pkg::ST_PICK:
            begin
                cmd.op  = dsfs_pkg::OP_PICK;
                cmd_idx = CW'(pickup);
            end
            dsfs_pkg::ST_PWAIT:
            begin
                cmd.op = dsfs_pkg::OP_NONE;
            end
            dsfs_pkg::ST_RESULT:
            begin
                out_load = out_free;
            end
            default:
            begin
                cmd.op = dsfs_pkg::OP_NONE;
            end
        endcase
    end

endmodule

// File: rtl/dsfs_datapath.sv
// Datapath of the string model: three plane memories, update pipeline, excitation and pickup.
`timescale 1ns / 1ps

module dsfs_datapath #(
    parameter int MAX_POINTS = 257,
    localparam int AW = $clog2(MAX_POINTS),
    localparam int IW = (AW > dsfs_pkg::GRID_W) ? AW : dsfs_pkg::GRID_W,
    localparam int CW = IW + 1
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  dsfs_pkg::ctrl_cmd_t                     cmd,
    input  logic [CW-1:0]                           cmd_idx,
    input  logic [dsfs_pkg::WIN_IDX_W-1:0]          cmd_win,
    input  logic [IW-1:0]                           n_eff,
    input  logic signed [dsfs_pkg::COEF_W-1:0]      coef_center,
    input  logic signed [dsfs_pkg::COEF_W-1:0]      coef_neighbour,
    input  logic signed [dsfs_pkg::COEF_W-1:0]      coef_previous,
    output logic signed [dsfs_pkg::DISP_W-1:0]      pickup_value,
    output logic                                    saturated
);

    localparam int DW = dsfs_pkg::DISP_W;

    // Adds two displacements and clips; the top bit flags clipping.
    function automatic logic [DW:0] add_sat(input logic signed [DW-1:0] a,
                                            input logic signed [DW-1:0] b);
        logic signed [DW:0] s;
        logic [DW:0]        r;
        s = {a[DW-1], a} + {b[DW-1], b};
        if (s[DW] != s[DW-1])
        begin
            r = {1'b1, (s[DW] ? dsfs_pkg::DISP_MIN : dsfs_pkg::DISP_MAX)};
        end
        else
        begin
            r = {1'b0, s[DW-1:0]};
        end
        return r;
    endfunction

    // Plane roles follow the rotation: next, current and previous.
    logic [1:0] rot_reg;
    logic [1:0] rot_next;
    logic [1:0] cur_sel;
    logic [1:0] prv_sel;

    logic [2:0]    ram_we;
    logic [AW-1:0] ram_waddr;
    logic [DW-1:0] ram_wdata [3];
    logic [DW-1:0] ram_rdata [3];

    dsfs_pkg::cmd_op_t              tag1_op_reg;
    logic [CW-1:0]                  tag1_idx_reg;
    logic [dsfs_pkg::WIN_IDX_W-1:0] tag1_win_reg;

    logic signed [DW-1:0] cur_raw;
    logic signed [DW-1:0] prv_raw;
    logic signed [DW-1:0] cur_q;
    logic signed [DW-1:0] prv_q;
    logic                 in_range1;

    logic signed [DW-1:0] cur_r0_reg, cur_r1_reg, cur_r2_reg;
    logic signed [DW-1:0] prv_r0_reg, prv_r1_reg;
    logic                 v2_reg;
    logic [CW-1:0]        l2_reg;

    logic signed [DW:0]   nb;
    logic signed [49:0]   prod_c_reg;
    logic signed [50:0]   prod_n_reg;
    logic signed [49:0]   prod_p_reg;
    logic                 v3_reg;
    logic [CW-1:0]        l3_reg;

    logic signed [52:0]   acc;
    logic signed [36:0]   rnd;
    logic [DW-1:0]        res_val;
    logic                 res_sat;
    logic [DW-1:0]        res_val_reg;
    logic                 res_sat_reg;
    logic                 v4_reg;
    logic [CW-1:0]        l4_reg;

    logic [DW:0]          exc_cur_sum;
    logic [DW:0]          exc_prv_sum;
    logic                 exc_v_reg;
    logic [CW-1:0]        exc_idx_reg;
    logic [DW-1:0]        exc_cur_reg;
    logic [DW-1:0]        exc_prv_reg;
    logic                 exc_sat_reg;

    logic signed [DW-1:0] pick_reg;
    logic                 sat_reg;

    always_comb
    begin
        case (rot_reg)
            2'd0:
            begin
                cur_sel = 2'd1;
                prv_sel = 2'd2;
            end
            2'd1:
            begin
                cur_sel = 2'd2;
                prv_sel = 2'd0;
            end
            default:
            begin
                cur_sel = 2'd0;
                prv_sel = 2'd1;
            end
        endcase
        if (cmd.rotate)
        begin
            rot_next = (rot_reg == 2'd0) ? 2'd2 : rot_reg - 2'd1;
        end
        else
        begin
            rot_next = rot_reg;
        end
    end

    // Write port sharing: clearing pass, tick write-back, excitation write-back.
    assign ram_waddr = (cmd.op == dsfs_pkg::OP_CLEAR) ? cmd_idx[AW-1:0] :
                       v4_reg                         ? l4_reg[AW-1:0]  :
                                                        exc_idx_reg[AW-1:0];

    for (genvar k = 0; k < 3; k++)
    begin : g_plane
        always_comb
        begin
            ram_we[k] = (cmd.op == dsfs_pkg::OP_CLEAR)
                     || (v4_reg && (rot_reg == 2'(k)))
                     || (exc_v_reg && ((cur_sel == 2'(k)) || (prv_sel == 2'(k))));
            if (cmd.op == dsfs_pkg::OP_CLEAR)
            begin
                ram_wdata[k] = '0;
            end
            else if (v4_reg)
            begin
                ram_wdata[k] = res_val_reg;
            end
            else if (cur_sel == 2'(k))
            begin
                ram_wdata[k] = exc_cur_reg;
            end
            else
            begin
                ram_wdata[k] = exc_prv_reg;
            end
        end

        dsfs_ram #(
            .WIDTH (DW),
            .DEPTH (MAX_POINTS)
        ) u_plane (
            .clk   (clk),
            .we    (ram_we[k]),
            .waddr (ram_waddr),
            .wdata (ram_wdata[k]),
            .raddr (cmd_idx[AW-1:0]),
            .rdata (ram_rdata[k])
        );
    end

    // Read stage: end points and points at or beyond N read as zero.
    always_comb
    begin
        cur_raw     = $signed(ram_rdata[cur_sel]);
        prv_raw     = $signed(ram_rdata[prv_sel]);
        in_range1   = (tag1_idx_reg != '0) && (tag1_idx_reg < CW'(n_eff));
        cur_q       = in_range1 ? cur_raw : '0;
        prv_q       = in_range1 ? prv_raw : '0;
        exc_cur_sum = add_sat(cur_raw, dsfs_pkg::win_value(tag1_win_reg));
        exc_prv_sum = add_sat(prv_raw, dsfs_pkg::win_value(tag1_win_reg));
    end

    // Neighbour sum and the rounding/clipping of the accumulated products.
    always_comb
    begin
        nb  = {cur_r0_reg[DW-1], cur_r0_reg} + {cur_r2_reg[DW-1], cur_r2_reg};
        acc = 53'(prod_c_reg) + 53'(prod_n_reg) + 53'(prod_p_reg) + 53'sd32768;
        rnd = acc[52:16];
        if (rnd[36:31] == {6{rnd[31]}})
        begin
            res_val = rnd[31:0];
            res_sat = 1'b0;
        end
        else
        begin
            res_val = rnd[36] ? dsfs_pkg::DISP_MIN : dsfs_pkg::DISP_MAX;
            res_sat = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_reg     <= 2'd0;
            tag1_op_reg <= dsfs_pkg::OP_NONE;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            exc_v_reg   <= 1'b0;
            sat_reg     <= 1'b0;
        end
        else
        begin
            rot_reg     <= rot_next;
            tag1_op_reg <= cmd.op;
            v2_reg      <= (tag1_op_reg == dsfs_pkg::OP_TICK) && (tag1_idx_reg >= CW'(2));
            v3_reg      <= v2_reg;
            v4_reg      <= v3_reg;
            exc_v_reg   <= (tag1_op_reg == dsfs_pkg::OP_EXCITE);
            if (cmd.start)
            begin
                sat_reg <= 1'b0;
            end
            else if ((v4_reg && res_sat_reg) || (exc_v_reg && exc_sat_reg))
            begin
                sat_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tag1_idx_reg <= cmd_idx;
        tag1_win_reg <= cmd_win;
        if (tag1_op_reg == dsfs_pkg::OP_TICK)
        begin
            cur_r0_reg <= cur_q;
            cur_r1_reg <= cur_r0_reg;
            cur_r2_reg <= cur_r1_reg;
            prv_r0_reg <= prv_q;
            prv_r1_reg <= prv_r0_reg;
        end
        if (tag1_op_reg == dsfs_pkg::OP_PICK)
        begin
            pick_reg <= cur_q;
        end
        l2_reg      <= tag1_idx_reg - CW'(1);
        prod_c_reg  <= coef_center * cur_r1_reg;
        prod_n_reg  <= coef_neighbour * nb;
        prod_p_reg  <= coef_previous * prv_r1_reg;
        l3_reg      <= l2_reg;
        res_val_reg <= res_val;
        res_sat_reg <= res_sat;
        l4_reg      <= l3_reg;
        exc_idx_reg <= tag1_idx_reg;
        exc_cur_reg <= exc_cur_sum[DW-1:0];
        exc_prv_reg <= exc_prv_sum[DW-1:0];
        exc_sat_reg <= exc_cur_sum[DW] | exc_prv_sum[DW];
    end

    assign pickup_value = pick_reg;
    assign saturated    = sat_reg;

endmodule

// File: rtl/dsfs_checker.sv
// Port-level checker for the string model, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dsfs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser
);

    // Items taken in but not yet delivered.
    logic [1:0]  outstanding_reg;
    logic        in_xfer;
    logic        out_xfer;
    logic        stall;
    logic [32:0] out_word;
    logic        have_item;
    logic        backlog_full;

    assign in_xfer      = s_tvalid && s_tready;
    assign out_xfer     = m_tvalid && m_tready;
    assign stall        = m_tvalid && !m_tready;
    assign out_word     = {m_tuser, m_tdata};
    assign have_item    = (outstanding_reg != 2'd0);
    assign backlog_full = (outstanding_reg == 2'd3);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= 2'd0;
        end
        else if (in_xfer && !out_xfer)
        begin
            outstanding_reg <= outstanding_reg + 2'd1;
        end
        else if (out_xfer && !in_xfer)
        begin
            outstanding_reg <= outstanding_reg - 2'd1;
        end
    end

    `ASSERT_NEXT(a_one_item_at_a_time, clk, rst_n, in_xfer, !s_tready, "input taken while busy")
    `ASSERT_IMPLIES(a_no_invented_result, clk, rst_n, m_tvalid, have_item, "result with no item")
    `ASSERT_IMPLIES(a_bounded_backlog, clk, rst_n, 1'b1, !backlog_full, "more than two items held")
    `ASSERT_NEXT(a_out_hold, clk, rst_n, stall, m_tvalid && $stable(out_word), "result changed")

endmodule

bind damped_string_fdtd_step dsfs_checker u_dsfs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
);
